// ===== sv/ylsd_pkg.sv =====
package ylsd_pkg;

  localparam int FRAC_BITS = 4;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 72;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int OP_W      = 18;
  localparam int PROD_W    = 2 * OP_W;
  localparam int GAIN_W    = 33;
  localparam int GAIN_LO_W = 17;
  localparam int BOUND_W   = 23 + FRAC_BITS;
  localparam int CMP_W     = 48;
  localparam int SUM_W     = 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_GAIN        = 3'd0,
    REG_SPEED_CUTOFF     = 3'd1,
    REG_SPEED_LIMIT      = 3'd2,
    REG_SPIN_THRESHOLD   = 3'd3,
    REG_SPIN_COUNT_LIMIT = 3'd4,
    REG_WINDOW_FRAMES    = 3'd5,
    REG_DISTANCE_GAIN    = 3'd6,
    REG_DISTANCE_OFFSET  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_SPEED   = 3'd0,
    MUL_SCALED  = 3'd1,
    MUL_GAIN    = 3'd2,
    MUL_LEAD_LO = 3'd3,
    MUL_LEAD_HI = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd_speed;
    logic     upd_spin;
    logic     upd_gain;
    logic     acc_lo;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== sv/ylsd_mul.sv =====
module ylsd_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [ylsd_pkg::OP_W-1:0]      a,
  input  logic signed [ylsd_pkg::OP_W-1:0]      b,
  output logic signed [ylsd_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ===== sv/ylsd_ctrl.sv =====
module ylsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ylsd_pkg::status_t status,
  output ylsd_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SPEED    = 8'b0000_0010,
    ST_SCALED   = 8'b0000_0100,
    ST_GAIN_MUL = 8'b0000_1000,
    ST_GAIN_ADD = 8'b0001_0000,
    ST_LEAD_LO  = 8'b0010_0000,
    ST_LEAD_HI  = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = ylsd_pkg::MUL_SPEED;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SPEED;
        end
      end
      ST_SPEED: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ylsd_pkg::MUL_SPEED;
        state_next  = ST_SCALED;
      end
      ST_SCALED: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = ylsd_pkg::MUL_SCALED;
        cmd.upd_speed = 1'b1;
        state_next    = ST_GAIN_MUL;
      end
      ST_GAIN_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = ylsd_pkg::MUL_GAIN;
        cmd.upd_spin = 1'b1;
        state_next   = ST_GAIN_ADD;
      end
      ST_GAIN_ADD: begin
        cmd.upd_gain = 1'b1;
        state_next   = ST_LEAD_LO;
      end
      ST_LEAD_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ylsd_pkg::MUL_LEAD_LO;
        state_next  = ST_LEAD_HI;
      end
      ST_LEAD_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ylsd_pkg::MUL_LEAD_HI;
        cmd.acc_lo  = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && status.out_busy |=> state == ST_FINISH)
    else $error("result step left while output register full");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_SPEED && !in_ready)
    else $error("accepted transaction did not start processing");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");
`endif

endmodule

// ===== sv/ylsd_dp.sv =====
module ylsd_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ylsd_pkg::cmd_t                         cmd,
  output ylsd_pkg::status_t                      status,
  input  logic [ylsd_pkg::IN_W-1:0]              in_data,
  input  logic                                   cfg_we,
  input  logic [ylsd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ylsd_pkg::CFG_DAT_W-1:0]         cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ylsd_pkg::OUT_W-1:0]             out_data
);

  localparam int F = ylsd_pkg::FRAC_BITS;

  logic [15:0] diff_gain, spin_threshold, distance_gain, distance_offset;
  logic [14:0] speed_cutoff, speed_limit;
  logic [7:0]  spin_count_limit;
  logic [9:0]  window_frames;

  logic signed [15:0] x_r, gyro_r, prev_x;
  logic [15:0]        dist_r;
  logic signed [16:0] d_r;

  logic signed [ylsd_pkg::OP_W-1:0]   mul_a, mul_b;
  logic signed [ylsd_pkg::PROD_W-1:0] prod, acc_r;

  logic signed [15:0]               speed_pre;
  logic [ylsd_pkg::GAIN_W-1:0]      gain_r;
  logic                             fwd_arm, rev_arm;
  logic [7:0]                       fwd_run, rev_run, fwd_lat, rev_lat;
  logic [9:0]                       phase;

  logic                             spinning;
  logic signed [15:0]               speed_fin;

  logic signed [15:0] out_target, out_speed, out_lead;
  logic               out_spin;
  logic [7:0]         out_fwd, out_rev;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_gain        <= 16'd18278;
      speed_cutoff     <= 15'd4800;
      speed_limit      <= 15'd640;
      spin_threshold   <= 16'd12800;
      spin_count_limit <= 8'd3;
      window_frames    <= 10'd160;
      distance_gain    <= 16'd2969;
      distance_offset  <= 16'd9830;
    end else if (cfg_we) begin
      case (ylsd_pkg::cfg_reg_t'(cfg_index))
        ylsd_pkg::REG_DIFF_GAIN:        diff_gain        <= cfg_data;
        ylsd_pkg::REG_SPEED_CUTOFF:     speed_cutoff     <= cfg_data[14:0];
        ylsd_pkg::REG_SPEED_LIMIT:      speed_limit      <= cfg_data[14:0];
        ylsd_pkg::REG_SPIN_THRESHOLD:   spin_threshold   <= cfg_data;
        ylsd_pkg::REG_SPIN_COUNT_LIMIT: spin_count_limit <= cfg_data[7:0];
        ylsd_pkg::REG_WINDOW_FRAMES:    window_frames    <= cfg_data[9:0];
        ylsd_pkg::REG_DISTANCE_GAIN:    distance_gain    <= cfg_data;
        ylsd_pkg::REG_DISTANCE_OFFSET:  distance_offset  <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the frame and its position difference
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= $signed(in_data[15:0]);
      dist_r <= in_data[31:16];
      gyro_r <= $signed(in_data[47:32]);
      d_r    <= $signed({in_data[15], in_data[15:0]}) - $signed({prev_x[15], prev_x});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
    end else if (cmd.load) begin
      prev_x <= $signed(in_data[15:0]);
    end
  end

  always_comb begin
    spinning  = (fwd_lat >= spin_count_limit) || (rev_lat >= spin_count_limit);
    speed_fin = spinning ? 16'sd0 : speed_pre;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      ylsd_pkg::MUL_SPEED: begin
        mul_a = {d_r[16], d_r};
        mul_b = $signed({2'b00, diff_gain});
      end
      ylsd_pkg::MUL_SCALED: begin
        mul_a = {d_r[16], d_r};
        mul_b = $signed({2'b00, dist_r});
      end
      ylsd_pkg::MUL_GAIN: begin
        mul_a = $signed({2'b00, dist_r});
        mul_b = $signed({2'b00, distance_gain});
      end
      ylsd_pkg::MUL_LEAD_LO: begin
        mul_a = {{2{speed_fin[15]}}, speed_fin};
        mul_b = $signed({1'b0, gain_r[ylsd_pkg::GAIN_LO_W-1:0]});
      end
      ylsd_pkg::MUL_LEAD_HI: begin
        mul_a = {{2{speed_fin[15]}}, speed_fin};
        mul_b = $signed({2'b00, gain_r[ylsd_pkg::GAIN_W-1:ylsd_pkg::GAIN_LO_W]});
      end
      default: ;
    endcase
  end

  ylsd_mul u_mul (
    .clk  (clk),
    .en   (cmd.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // speed: round, subtract gyro, cutoff, clamp
  logic signed [ylsd_pkg::PROD_W-1:0] rnd;
  logic signed [22:0]                 speed_raw, cut, lim, speed_cl;

  always_comb begin
    rnd       = (prod + ylsd_pkg::PROD_W'(2048)) >>> 12;
    speed_raw = rnd[22:0] - {{7{gyro_r[15]}}, gyro_r};
    cut       = $signed({8'b0, speed_cutoff});
    lim       = $signed({8'b0, speed_limit});
    speed_cl  = speed_raw;
    if (speed_raw > cut || speed_raw < -cut) begin
      speed_cl = '0;
    end
    if (speed_cl > lim) begin
      speed_cl = lim;
    end else if (speed_cl < -lim) begin
      speed_cl = -lim;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_speed) begin
      speed_pre <= speed_cl[15:0];
    end
  end

  // reversal detection and window latching
  logic signed [ylsd_pkg::CMP_W-1:0] scaled, bound;
  logic [ylsd_pkg::BOUND_W-1:0]      bound_u;
  logic [10:0]                       win, phase_inc;
  logic                              fwd_arm_next, rev_arm_next;
  logic [7:0]                        fwd_run_next, rev_run_next, fwd_lat_next, rev_lat_next;
  logic [9:0]                        phase_next;

  always_comb begin
    scaled = (dist_r != 16'd0) ? ylsd_pkg::CMP_W'(prod) : '0;
    bound_u = ((ylsd_pkg::BOUND_W'(spin_threshold) << 6)
             + (ylsd_pkg::BOUND_W'(spin_threshold) << 5)
             + (ylsd_pkg::BOUND_W'(spin_threshold) << 2)) << F;
    bound  = $signed(ylsd_pkg::CMP_W'(bound_u));

    rev_arm_next = rev_arm;
    rev_run_next = rev_run;
    fwd_arm_next = fwd_arm;
    fwd_run_next = fwd_run;
    if (scaled < -bound) begin
      rev_arm_next = 1'b1;
    end
    if (rev_arm_next && scaled >= 0) begin
      rev_arm_next = 1'b0;
      rev_run_next = (rev_run == 8'd255) ? rev_run : rev_run + 8'd1;
    end
    if (scaled > bound) begin
      fwd_arm_next = 1'b1;
    end
    if (fwd_arm_next && scaled <= 0) begin
      fwd_arm_next = 1'b0;
      fwd_run_next = (fwd_run == 8'd255) ? fwd_run : fwd_run + 8'd1;
    end

    fwd_lat_next = fwd_lat;
    rev_lat_next = rev_lat;
    if (phase == 10'd0) begin
      fwd_lat_next = fwd_run_next;
      rev_lat_next = rev_run_next;
      fwd_run_next = '0;
      rev_run_next = '0;
    end

    win        = (window_frames == 10'd0) ? 11'd1 : {1'b0, window_frames};
    phase_inc  = {1'b0, phase} + 11'd1;
    phase_next = (phase_inc >= win) ? 10'd0 : phase_inc[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_arm <= 1'b0;
      rev_arm <= 1'b0;
      fwd_run <= '0;
      rev_run <= '0;
      fwd_lat <= '0;
      rev_lat <= '0;
      phase   <= '0;
    end else if (cmd.upd_spin) begin
      fwd_arm <= fwd_arm_next;
      rev_arm <= rev_arm_next;
      fwd_run <= fwd_run_next;
      rev_run <= rev_run_next;
      fwd_lat <= fwd_lat_next;
      rev_lat <= rev_lat_next;
      phase   <= phase_next;
    end
  end

  // lead gain and two-part product
  always_ff @(posedge clk) begin
    if (cmd.upd_gain) begin
      gain_r <= ylsd_pkg::GAIN_W'(prod[31:0])
              + (ylsd_pkg::GAIN_W'(distance_offset) << (4 + F));
    end
    if (cmd.acc_lo) begin
      acc_r <= prod;
    end
  end

  logic signed [ylsd_pkg::SUM_W-1:0] total, lead_full, target_full;
  logic signed [15:0]                lead_sat, target_sat;

  function automatic logic signed [15:0] sat16(input logic signed [ylsd_pkg::SUM_W-1:0] v);
    logic signed [15:0] r;
    if (v > ylsd_pkg::SUM_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -ylsd_pkg::SUM_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    total       = ylsd_pkg::SUM_W'(acc_r)
                + (ylsd_pkg::SUM_W'(prod) <<< ylsd_pkg::GAIN_LO_W);
    lead_full   = (total + (ylsd_pkg::SUM_W'(1) <<< (15 + F))) >>> (16 + F);
    target_full = ylsd_pkg::SUM_W'(x_r) + lead_full;
    lead_sat    = sat16(lead_full);
    target_sat  = sat16(target_full);
  end

  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_target <= target_sat;
      out_speed  <= speed_fin;
      out_lead   <= lead_sat;
      out_spin   <= spinning;
      out_fwd    <= fwd_lat;
      out_rev    <= rev_lat;
    end
  end

  assign out_data = {7'b0, out_rev, out_fwd, out_spin, out_lead, out_speed, out_target};

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("output register loaded while a result is still held");

  a_spin_cancels: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_spin |-> out_speed == 16'sd0)
    else $error("spinning result carries non-zero speed");

  a_window_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_spin && phase == 10'd0 |=> fwd_run == 8'd0 && rev_run == 8'd0)
    else $error("running counts not cleared at window latch");
`endif

endmodule

// ===== sv/yaw_lead_with_spin_detection_core.sv =====
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  target_x, target_distance, gyro_yaw_rate
// m_axis    out        m_axis_tvalid / m_axis_tready  yaw_target .. reverse_spins
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A frame steps through speed, scaled, gain multiply, gain add, lead low, lead high and
// finish between acceptance and the output register: five products share one registered
// 18x18 multiplier, the lead product being split in two halves.
// A new transaction is taken once the previous one has reached the output register;
// the next frame holds in its last step while that result waits for m_axis_tready.
// rst is synchronous and clears all history; cfg_ready is always high, write only
// while no frame is in flight.
module yaw_lead_with_spin_detection_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] target_x, [31:16] target_distance, [47:32] gyro_yaw_rate
  input  logic [ylsd_pkg::IN_W-1:0]           s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] yaw_target, [31:16] relative_speed, [47:32] lead_offset,
  // [48] spin_active, [56:49] forward_spins, [64:57] reverse_spins, [71:65] zero
  output logic [ylsd_pkg::OUT_W-1:0]          m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ylsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ylsd_pkg::CFG_DAT_W-1:0]      cfg_data
);

  ylsd_pkg::cmd_t    cmd;
  ylsd_pkg::status_t status;

  assign cfg_ready = 1'b1;

  ylsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ylsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
